// File: sv/stts_pkg.sv
// Shared types and constants for the sorted table ternary search block.
// Item, result, controller command and status structs; opcode and register codes.
// No dependencies.
package stts_pkg;

	localparam int IDX_W  = 4;             // table index, range register width
	localparam int POS_W  = IDX_W + 1;     // one-based position
	localparam int SPAN_W = IDX_W + 2;     // signed bound, holds -1 .. 2**IDX_W
	localparam int KEY_W  = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

	typedef struct packed {
		logic                     opcode;
		logic [IDX_W-1:0]         entry_index;
		logic signed [KEY_W-1:0]  word;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

	typedef struct packed {
		logic write;        // store the item's word in the table
		logic load;         // capture key and search bounds
		logic issue;        // latch probe points and read both
		logic step;         // narrow the bounds
		logic finish_hit;
		logic finish_miss;
	} cmd_t;

	typedef struct packed {
		logic empty;        // lo > hi
		logic hit1;
		logic hit2;
	} status_t;

	// floor(d / 3) for d in 0..15: reciprocal multiply, (d * 11) >> 5
	function automatic logic [IDX_W-1:0] third_of(input logic [IDX_W-1:0] d);
		logic [IDX_W+4:0] prod;
		prod = (IDX_W+5)'(d) * (IDX_W+5)'(11);
		return prod[IDX_W+4:5];
	endfunction

endpackage

// File: sv/stts_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module stts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: sv/stts_ctrl.sv
// Controller FSM for the ternary search: sequences load, probe, compare, finish.
// Depends on stts_pkg for command and status structs.
module stts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             opcode,
	input  stts_pkg::status_t status,
	output logic             busy,
	output logic             done,
	output stts_pkg::cmd_t   cmd
);
	import stts_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_COMP  = 2'd2;

	logic [1:0] state_q, state_d;
	logic       done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (opcode == OP_SEARCH) begin
						cmd.load = 1'b1;
						state_d  = ST_SETUP;
					end else begin
						cmd.write = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				if (status.empty) begin
					cmd.finish_miss = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					cmd.issue = 1'b1;
					state_d   = ST_COMP;
				end
			end
			ST_COMP: begin
				// read data for the latched probes is valid here
				if (status.hit1 || status.hit2) begin
					cmd.finish_hit = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish_hit | cmd.finish_miss;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_done_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("done strobe outside idle");

	a_done_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_SETUP || $past(state_q) == ST_COMP))
		else $error("done strobe without a search step");

	a_issue_then_compare: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> state_q == ST_COMP)
		else $error("probe issued but compare state not reached");

endmodule

// File: sv/stts_dpath.sv
// Datapath for the ternary search: table RAM, key and bounds, probe points, result.
// Depends on stts_pkg and stts_ram.
module stts_dpath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  stts_pkg::cmd_t                  cmd,
	input  stts_pkg::item_t                 item,
	input  logic [stts_pkg::IDX_W-1:0]      range_low,
	input  logic [stts_pkg::IDX_W-1:0]      range_high,
	output stts_pkg::status_t               status,
	output stts_pkg::result_t               result
);
	import stts_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int LAST = DEPTH - 1;

	logic signed [DATA_WIDTH-1:0] key_q;
	logic signed [SPAN_W-1:0]     lo_q, hi_q;
	logic signed [SPAN_W-1:0]     span, m1, m2;
	logic signed [SPAN_W-1:0]     m1_ext, m2_ext;
	logic [IDX_W-1:0]             p;
	logic [IDX_W-1:0]             m1_q, m2_q;
	logic [DATA_WIDTH-1:0]        rdata_a, rdata_b;
	logic signed [DATA_WIDTH-1:0] v1, v2;
	logic                         we;
	result_t                      result_q;

	// probe points from current bounds
	assign span = hi_q - lo_q;
	assign p    = third_of(span[IDX_W-1:0]);
	assign m1   = lo_q + $signed(SPAN_W'(p));
	assign m2   = hi_q - $signed(SPAN_W'(p));

	assign m1_ext = $signed(SPAN_W'(m1_q));
	assign m2_ext = $signed(SPAN_W'(m2_q));

	assign we = cmd.write && (int'(item.entry_index) < DEPTH);

	stts_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (AW'(item.entry_index)),
		.wdata   (DATA_WIDTH'($unsigned(item.word))),
		.raddr_a (AW'(m1[IDX_W-1:0])),
		.raddr_b (AW'(m2[IDX_W-1:0])),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	assign v1 = $signed(rdata_a);
	assign v2 = $signed(rdata_b);

	assign status.empty = (lo_q > hi_q);
	assign status.hit1  = (v1 == key_q);
	assign status.hit2  = (v2 == key_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= DATA_WIDTH'(item.word);   // sign-extends or truncates
			lo_q  <= $signed(SPAN_W'(range_low));
			if (int'(range_high) > LAST) begin
				hi_q <= SPAN_W'(LAST);
			end else begin
				hi_q <= $signed(SPAN_W'(range_high));
			end
		end else if (cmd.step) begin
			if (key_q < v1) begin
				hi_q <= m1_ext - SPAN_W'(1);
			end else if (key_q > v2) begin
				lo_q <= m2_ext + SPAN_W'(1);
			end else begin
				lo_q <= m1_ext + SPAN_W'(1);
				hi_q <= m2_ext - SPAN_W'(1);
			end
		end
		if (cmd.issue) begin
			m1_q <= m1[IDX_W-1:0];
			m2_q <= m2[IDX_W-1:0];
		end
		if (cmd.finish_miss) begin
			result_q.found    <= 1'b0;
			result_q.position <= '0;
		end else if (cmd.finish_hit) begin
			// mid1 wins over mid2
			result_q.found    <= 1'b1;
			result_q.position <= status.hit1 ? POS_W'(m1_q) + POS_W'(1)
			                                 : POS_W'(m2_q) + POS_W'(1);
		end
	end

	assign result = result_q;

	a_probe_order: assert property (@(posedge clk)
		cmd.issue |=> m1_q <= m2_q)
		else $error("probe points out of order");

	a_probe_in_range: assert property (@(posedge clk)
		cmd.issue |-> (m1 >= lo_q && m2 <= hi_q))
		else $error("probe point outside bounds");

endmodule

// File: sv/sorted_table_ternary_search.sv
// Top level of the sorted table ternary search block.
// Holds the range registers and joins controller and datapath.
// Depends on stts_pkg, stts_ctrl, stts_dpath, stts_ram.
//
// Usage:
//   Items enter on item when start is high and busy is low. A write item
//   (opcode OP_WRITE) stores word at entry_index and gives no result; busy
//   stays low, so writes can be issued every cycle. A search
//   item (OP_SEARCH) raises busy and runs the ternary search over
//   range_low..range_high; one result word appears on result with done high
//   for exactly one cycle. The receiver cannot stall: a result is taken in
//   the cycle it is shown.
//   Each narrowing step runs a probe read, then a compare, through the
//   dual-read table RAM; a search ends on a probe hit or an empty range.
//   busy drops in the cycle done is high, so the next item can be taken then.
//   The range registers are written on the cfg channel (cfg_valid with
//   cfg_ready, always ready); the user must do so only while the block is
//   idle, as the block itself does not enforce it.
//   Reset clears the controller and sets the range to 0..15; table contents
//   are undefined until written.
module sorted_table_ternary_search #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  stts_pkg::item_t               item,
	output logic                          done,
	output stts_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stts_pkg::IDX_W-1:0]    cfg_data
);
	import stts_pkg::*;

	logic [IDX_W-1:0] range_low_q, range_high_q;
	cmd_t             cmd;
	status_t          status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RANGE_LOW:  range_low_q  <= cfg_data;
				CFG_RANGE_HIGH: range_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	stts_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (item.opcode),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	stts_dpath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dpath (
		.clk        (clk),
		.cmd        (cmd),
		.item       (item),
		.range_low  (range_low_q),
		.range_high (range_high_q),
		.status     (status),
		.result     (result)
	);

	a_result_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.found == (result.position != '0)))
		else $error("found flag disagrees with position");

endmodule
